FILE: hdl/stt_pkg.sv
// Package for the search transposition table: table geometry, score constants,
// bound and mode codes, entry layout and the request/response word types.
// No dependencies.
`default_nettype none

package stt_pkg;

	// Table geometry
	localparam int TABLE_ENTRIES = 65536;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int KEY_W         = 64;
	localparam int TAG_W         = KEY_W - IDX_W;

	// Entry word: score 15:0, move 31:16, depth 39:32, bound 47:40
	localparam int ENTRY_W    = 48;
	localparam int MEM_W      = TAG_W + ENTRY_W;
	localparam int SCORE_LSB  = 0;
	localparam int MOVE_LSB   = 16;
	localparam int DEPTH_LSB  = 32;
	localparam int BOUND_LSB  = 40;

	// Score constants
	localparam int MAX_DEPTH_PLY = 64;
	localparam int MATE_VALUE    = 29000;
	localparam int MATE_BOUND    = MATE_VALUE - MAX_DEPTH_PLY;

	localparam logic signed [16:0] MATE_BOUND_X = 17'(MATE_BOUND);
	localparam logic signed [16:0] SCORE_MAX_X  = 17'(32767);
	localparam logic signed [16:0] SCORE_MIN_X  = -17'(32768);

	// Item codes
	localparam logic MODE_PROBE = 1'b0;
	localparam logic MODE_STORE = 1'b1;

	localparam logic [1:0] BOUND_NONE  = 2'd0;
	localparam logic [1:0] BOUND_EXACT = 2'd1;
	localparam logic [1:0] BOUND_LOWER = 2'd2;
	localparam logic [1:0] BOUND_UPPER = 2'd3;

	typedef enum logic {
		ST_CLEAR,
		ST_RUN
	} stt_state_t;

	typedef struct packed {
		logic               mode;
		logic [KEY_W-1:0]   key;
		logic signed [15:0] alpha;
		logic signed [15:0] beta;
		logic [7:0]         depth;
		logic [5:0]         ply;
		logic signed [15:0] score;
		logic [15:0]        store_move;
		logic [1:0]         bound;
	} req_word_t;

	typedef struct packed {
		logic               hit;
		logic [15:0]        hash_move;
		logic               cutoff;
		logic signed [15:0] cutoff_score;
	} rsp_word_t;

endpackage

`default_nettype wire

FILE: hdl/search_transposition_table_top.sv
// Top level of the search transposition table: one synchronous table memory,
// a two-stage read/modify/write pipe and a registered response word.
// Depends on stt_pkg.
//
// Usage:
//   Request channel (req_valid / req_stall / req) carries probe and store
//   words; response channel (rsp_valid / rsp_stall / rsp) returns exactly one
//   word per request, in order. Store requests return an all-zero word.
//   Order: an accepted request is held in stage 1 with its table read, and
//   its response word is then held in the response register.
//   Throughput: one request per cycle unless stalled. The table memory is read
//   once per request and written once per store; a store followed at once by
//   a request to the same slot is served by forwarding the written entry.
//   Stall: while rsp_stall holds a waiting response, the pipe stage behind it
//   holds too and req_stall rises; nothing is dropped. One more request is
//   still taken while the response register is full but the pipe is empty.
//   Reset: arst_n clears control state, then a clearing pass writes zero to
//   every slot, one per cycle, with req_stall high until all TABLE_ENTRIES
//   (65536) slots are written. After that requests are taken.
//   Lookup: slot = low IDX_W key bits, the rest of the key is kept as a tag.
//   A hit needs a tag match and a nonzero entry word.
`default_nettype none

module search_transposition_table_top
	import stt_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_stall,
	input  wire req_word_t req,
	output logic           rsp_valid,
	input  wire logic      rsp_stall,
	output rsp_word_t      rsp
);

	// Table memory: {tag, entry word} per slot
	logic [MEM_W-1:0] table_mem [TABLE_ENTRIES];

	stt_state_t       state_q, state_nxt;
	logic [IDX_W-1:0] clr_idx_q;
	logic             clr_last;

	// Pipe stage 1: the accepted request and its table read
	logic             valid_s1;
	req_word_t        item_s1;
	logic [MEM_W-1:0] rd_s1;
	logic             fwd_s1;
	logic [MEM_W-1:0] fwd_word_s1;

	// Response register
	logic      rsp_valid_q;
	rsp_word_t rsp_q;

	logic             accept;
	logic             adv_s1;
	logic             wr_en;
	logic [IDX_W-1:0] wr_idx;
	logic [MEM_W-1:0] wr_word;
	logic [MEM_W-1:0] slot_word;
	rsp_word_t        result;

	// Store path
	logic [1:0]         st_bound;
	logic signed [16:0] st_score_x;
	logic signed [16:0] st_ply_x;
	logic signed [16:0] st_up;
	logic signed [16:0] st_dn;
	logic signed [16:0] st_adj;
	logic [ENTRY_W-1:0] st_entry;

	// Probe path
	logic [ENTRY_W-1:0] pr_entry;
	logic [TAG_W-1:0]   pr_tag;
	logic               pr_hit;
	logic [7:0]         pr_bound;
	logic [7:0]         pr_depth;
	logic signed [16:0] pr_score_x;
	logic signed [16:0] pr_ts;
	logic signed [17:0] pr_window;
	logic signed [16:0] pr_alpha_x;
	logic signed [16:0] pr_beta_x;
	logic               pr_cut_ok;
	logic               pr_cut;

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign clr_last  = (clr_idx_q == {IDX_W{1'b1}});

	// Stage 1 moves on when the response register is free or being taken
	assign adv_s1 = ~rsp_valid_q | ~rsp_stall;
	assign accept = req_valid & ~req_stall;

	// Controller: clearing pass after reset, then normal operation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_idx_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_CLEAR) begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		req_stall = 1'b1;
		case (state_q)
			ST_CLEAR: begin
				if (clr_last) begin
					state_nxt = ST_RUN;
				end
			end
			ST_RUN: begin
				// hold requests while stage 1 is full and blocked
				req_stall = valid_s1 & ~adv_s1;
			end
			default: begin
				state_nxt = ST_CLEAR;
			end
		endcase
	end

	// Store entry: promote upper bound to exact when score > alpha, move mate scores away from zero
	always_comb begin
		st_bound = item_s1.bound;
		if (item_s1.bound == BOUND_UPPER && item_s1.score > item_s1.alpha) begin
			st_bound = BOUND_EXACT;
		end
		st_score_x = 17'(item_s1.score);
		st_ply_x   = $signed({11'd0, item_s1.ply});
		st_up      = st_score_x + st_ply_x;
		st_dn      = st_score_x - st_ply_x;
		if (st_score_x >= MATE_BOUND_X) begin
			st_adj = (st_up > SCORE_MAX_X) ? SCORE_MAX_X : st_up;
		end else if (st_score_x <= -MATE_BOUND_X) begin
			st_adj = (st_dn < SCORE_MIN_X) ? SCORE_MIN_X : st_dn;
		end else begin
			st_adj = st_score_x;
		end
		st_entry = {6'd0, st_bound, item_s1.depth, item_s1.store_move, st_adj[15:0]};
	end

	// Memory write: clearing pass or a store leaving stage 1
	always_comb begin
		if (state_q == ST_CLEAR) begin
			wr_en   = 1'b1;
			wr_idx  = clr_idx_q;
			wr_word = '0;
		end else begin
			wr_en   = valid_s1 & adv_s1 & (item_s1.mode == MODE_STORE);
			wr_idx  = item_s1.key[IDX_W-1:0];
			wr_word = {item_s1.key[KEY_W-1:IDX_W], st_entry};
		end
	end

	// Probe: the slot as it stands after any store just ahead
	always_comb begin
		slot_word  = fwd_s1 ? fwd_word_s1 : rd_s1;
		pr_entry   = slot_word[ENTRY_W-1:0];
		pr_tag     = slot_word[MEM_W-1:ENTRY_W];
		pr_hit     = (pr_tag == item_s1.key[KEY_W-1:IDX_W]) && (pr_entry != '0);
		pr_bound   = pr_entry[BOUND_LSB +: 8];
		pr_depth   = pr_entry[DEPTH_LSB +: 8];
		pr_score_x = 17'($signed(pr_entry[SCORE_LSB +: 16]));
		pr_alpha_x = 17'(item_s1.alpha);
		pr_beta_x  = 17'(item_s1.beta);
		// move mate scores back toward zero
		if (pr_score_x >= MATE_BOUND_X) begin
			pr_ts = pr_score_x - $signed({11'd0, item_s1.ply});
		end else if (pr_score_x <= -MATE_BOUND_X) begin
			pr_ts = pr_score_x + $signed({11'd0, item_s1.ply});
		end else begin
			pr_ts = pr_score_x;
		end
		pr_window = 18'(item_s1.beta) - 18'(item_s1.alpha);
		pr_cut_ok = pr_hit && (item_s1.ply != 6'd0) && (pr_window <= 18'sd1)
			&& (pr_depth >= item_s1.depth) && (pr_bound != 8'd0);
		pr_cut = pr_cut_ok && (
			(pr_bound == {6'd0, BOUND_EXACT})
			|| (pr_bound == {6'd0, BOUND_LOWER} && pr_ts >= pr_beta_x)
			|| (pr_bound == {6'd0, BOUND_UPPER} && pr_ts <= pr_alpha_x));

		result = '0;
		if (item_s1.mode == MODE_PROBE) begin
			result.hit       = pr_hit;
			result.hash_move = pr_hit ? pr_entry[MOVE_LSB +: 16] : 16'd0;
			result.cutoff    = pr_cut;
			result.cutoff_score = pr_cut ? pr_ts[15:0] : 16'sd0;
		end
	end

	// Pipe control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			fwd_s1      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				// forward a store to the same slot written at this edge
				fwd_s1   <= wr_en && (wr_idx == req.key[IDX_W-1:0]);
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				rsp_valid_q <= valid_s1;
			end
		end
	end

	// Payload registers and table memory
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1     <= req;
			rd_s1       <= table_mem[req.key[IDX_W-1:0]];
			fwd_word_s1 <= wr_word;
		end
		if (adv_s1) begin
			rsp_q <= result;
		end
		if (wr_en) begin
			table_mem[wr_idx] <= wr_word;
		end
	end

endmodule

`default_nettype wire
